// ===== design/dcsa_pkg.sv =====
package dcsa_pkg;

  // Fraction bits of the input fields and of the wave number.
  localparam int FRAC_BITS = 16;
  localparam int WIDEN_SH  = 32 - FRAC_BITS;

  // Q32.32 constants, rounded to nearest.
  localparam logic [63:0] FOUR_PI_Q32    = 64'h0000_000C_90FD_AA22;
  localparam logic [63:0] TWO_THIRDS_Q32 = 64'h0000_0000_AAAA_AAAB;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTITY    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_NUMBER = 2'd1;
  localparam int CFG_DATA_W = 31;

  typedef struct packed {
    logic signed [31:0] moment_re;
    logic signed [31:0] moment_im;
    logic signed [31:0] field_re;
    logic signed [31:0] field_im;
    logic signed [31:0] coef_re;
    logic signed [31:0] coef_im;
    logic               void_site;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] cross_section;
    logic               saturated;
  } out_item_t;

  // Micro-operation codes of the sequencer.
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_CHK  = 3'd3;
  localparam logic [2:0] OP_DONE = 3'd4;

  // Operand sources.
  localparam logic [3:0] SRC_ZERO   = 4'd0;
  localparam logic [3:0] SRC_PR     = 4'd1;
  localparam logic [3:0] SRC_PI     = 4'd2;
  localparam logic [3:0] SRC_ER     = 4'd3;
  localparam logic [3:0] SRC_EI     = 4'd4;
  localparam logic [3:0] SRC_CR     = 4'd5;
  localparam logic [3:0] SRC_CI     = 4'd6;
  localparam logic [3:0] SRC_K      = 4'd7;
  localparam logic [3:0] SRC_TWO3   = 4'd8;
  localparam logic [3:0] SRC_FOURPI = 4'd9;
  localparam logic [3:0] SRC_SUM    = 4'd10;
  localparam logic [3:0] SRC_T0     = 4'd11;
  localparam logic [3:0] SRC_T1     = 4'd12;
  localparam logic [3:0] SRC_T2     = 4'd13;

  // Result destinations.
  localparam logic [1:0] DST_T0  = 2'd0;
  localparam logic [1:0] DST_T1  = 2'd1;
  localparam logic [1:0] DST_T2  = 2'd2;
  localparam logic [1:0] DST_SUM = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [1:0] dst;
  } uop_t;

  function automatic uop_t mk_uop(input logic [2:0] op, input logic [3:0] src_a,
                                  input logic [3:0] src_b, input logic [1:0] dst);
    uop_t u;
    u.op    = op;
    u.src_a = src_a;
    u.src_b = src_b;
    u.dst   = dst;
    return u;
  endfunction

endpackage

// ===== design/dipole_cross_section_accumulator.sv =====
// An item is taken while the block is idle, then runs as a micro-program on one shared
// 64x64 multiplier built from a 32x32 multiplier; a last item adds a scaling tail
// before the result is registered. Items are taken one at a time; a void item that
// is not last leaves the block idle.
// Reset (rst, synchronous): clears the sum, overflow flag, sequencer and output valid,
// and restores the quantity and wave number registers to their defaults.
module dipole_cross_section_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dcsa_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dcsa_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dcsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dcsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;

  logic [1:0]   state;
  logic         tail;
  logic [3:0]   step;
  logic [2:0]   mul_cnt;
  in_item_t     item;

  logic [1:0]   quantity;
  logic [30:0]  wave_number;

  logic [63:0]  running_sum;
  logic         overflow_seen;
  logic [63:0]  t0, t1, t2;

  logic [63:0]  mul_a, mul_b;
  logic         mul_neg;
  logic [1:0]   mul_dst;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;

  uop_t         uop;
  logic [63:0]  opa, opb;
  logic [63:0]  alu_val;
  logic         alu_sat;
  logic [63:0]  mul_val;
  logic         mul_sat;
  logic [31:0]  a_half, b_half;
  logic [127:0] pp_ext;
  logic         in_fire;
  logic         out_free;
  logic         res_load;

  function automatic logic [63:0] widen(input logic [31:0] x);
    return {{32{x[31]}}, x} << WIDEN_SH;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic uop_t decode(input logic is_tail, input logic [1:0] qty,
                                  input logic [3:0] idx);
    uop_t u;
    u = mk_uop(OP_DONE, SRC_ZERO, SRC_ZERO, DST_T0);
    if (is_tail) begin
      unique case (idx)
        4'd0: u = mk_uop(OP_MUL, SRC_FOURPI, SRC_K, DST_T0);
        4'd1: u = mk_uop(OP_MUL, SRC_SUM, SRC_T0, DST_T0);
        4'd2: u = qty[1] ? mk_uop(OP_SUB, SRC_ZERO, SRC_T0, DST_T0)
                         : mk_uop(OP_DONE, SRC_ZERO, SRC_ZERO, DST_T0);
        default: u = mk_uop(OP_DONE, SRC_ZERO, SRC_ZERO, DST_T0);
      endcase
    end else if (qty == 2'd1) begin
      // Absorption: |P|^2 * (ci - d*|c|^2), d = 2k^3/3.
      unique case (idx)
        4'd0:  u = mk_uop(OP_MUL, SRC_K,  SRC_K,    DST_T0);
        4'd1:  u = mk_uop(OP_MUL, SRC_T0, SRC_K,    DST_T0);
        4'd2:  u = mk_uop(OP_MUL, SRC_T0, SRC_TWO3, DST_T0);
        4'd3:  u = mk_uop(OP_MUL, SRC_CR, SRC_CR,   DST_T1);
        4'd4:  u = mk_uop(OP_MUL, SRC_CI, SRC_CI,   DST_T2);
        4'd5:  u = mk_uop(OP_ADD, SRC_T1, SRC_T2,   DST_T1);
        4'd6:  u = mk_uop(OP_MUL, SRC_T0, SRC_T1,   DST_T0);
        4'd7:  u = mk_uop(OP_SUB, SRC_CI, SRC_T0,   DST_T0);
        4'd8:  u = mk_uop(OP_MUL, SRC_PR, SRC_PR,   DST_T1);
        4'd9:  u = mk_uop(OP_MUL, SRC_PI, SRC_PI,   DST_T2);
        4'd10: u = mk_uop(OP_ADD, SRC_T1, SRC_T2,   DST_T1);
        4'd11: u = mk_uop(OP_MUL, SRC_T1, SRC_T0,   DST_T0);
        4'd12: u = mk_uop(OP_ADD, SRC_SUM, SRC_T0,  DST_SUM);
        default: u = mk_uop(OP_CHK, SRC_ZERO, SRC_ZERO, DST_T0);
      endcase
    end else begin
      // Extinction and difference share most products; the cross terms and the last combine differ.
      unique case (idx)
        4'd0: u = mk_uop(OP_MUL, SRC_ER, SRC_PR, DST_T0);
        4'd1: u = mk_uop(OP_MUL, SRC_EI, SRC_PI, DST_T1);
        4'd2: u = mk_uop(OP_ADD, SRC_T0, SRC_T1, DST_T2);
        4'd3: u = qty[1] ? mk_uop(OP_MUL, SRC_PI, SRC_ER, DST_T0)
                         : mk_uop(OP_MUL, SRC_EI, SRC_PR, DST_T0);
        4'd4: u = qty[1] ? mk_uop(OP_MUL, SRC_PR, SRC_EI, DST_T1)
                         : mk_uop(OP_MUL, SRC_ER, SRC_PI, DST_T1);
        4'd5: u = mk_uop(OP_SUB, SRC_T0, SRC_T1, DST_T0);
        4'd6: u = mk_uop(OP_MUL, SRC_CI, SRC_T2, DST_T1);
        4'd7: u = mk_uop(OP_MUL, SRC_CR, SRC_T0, DST_T0);
        4'd8: u = qty[1] ? mk_uop(OP_ADD, SRC_T1, SRC_T0, DST_T0)
                         : mk_uop(OP_SUB, SRC_T1, SRC_T0, DST_T0);
        4'd9: u = mk_uop(OP_ADD, SRC_SUM, SRC_T0, DST_SUM);
        default: u = mk_uop(OP_CHK, SRC_ZERO, SRC_ZERO, DST_T0);
      endcase
    end
    return u;
  endfunction

  function automatic logic [63:0] source(input logic [3:0] code, input in_item_t it,
                                         input logic [30:0] k, input logic [63:0] sum,
                                         input logic [63:0] r0, input logic [63:0] r1,
                                         input logic [63:0] r2);
    logic [63:0] v;
    unique case (code)
      SRC_PR:     v = widen(it.moment_re);
      SRC_PI:     v = widen(it.moment_im);
      SRC_ER:     v = widen(it.field_re);
      SRC_EI:     v = widen(it.field_im);
      SRC_CR:     v = widen(it.coef_re);
      SRC_CI:     v = widen(it.coef_im);
      SRC_K:      v = {33'd0, k} << WIDEN_SH;
      SRC_TWO3:   v = TWO_THIRDS_Q32;
      SRC_FOURPI: v = FOUR_PI_Q32;
      SRC_SUM:    v = sum;
      SRC_T0:     v = r0;
      SRC_T1:     v = r1;
      SRC_T2:     v = r2;
      default:    v = 64'd0;
    endcase
    return v;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign res_load  = (state == S_RUN) && (uop.op == OP_DONE) && out_free;

  always_comb begin
    logic signed [64:0] s;
    uop = decode(tail, quantity, step);
    opa = source(uop.src_a, item, wave_number, running_sum, t0, t1, t2);
    opb = source(uop.src_b, item, wave_number, running_sum, t0, t1, t2);
    if (uop.op == OP_SUB) begin
      s = $signed({opa[63], opa}) - $signed({opb[63], opb});
    end else begin
      s = $signed({opa[63], opa}) + $signed({opb[63], opb});
    end
    alu_sat = s[64] ^ s[63];
    alu_val = alu_sat ? (s[64] ? SAT_MIN : SAT_MAX) : s[63:0];
  end

  // Partial products: a0*b0, a0*b1, a1*b0, a1*b1 in counts 0 to 3.
  assign a_half = mul_cnt[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_half = mul_cnt[0] ? mul_b[63:32] : mul_b[31:0];

  always_comb begin
    unique case (pp_sh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
  end

  // The product is taken as bits 95:32 of the exact magnitude product; it saturates
  // when upper bits are set or the magnitude exceeds the signed limit for its sign.
  always_comb begin
    logic [63:0] r;
    logic        too_big;
    r       = acc[95:32];
    too_big = mul_neg ? (r[63] && (|r[62:0])) : r[63];
    mul_sat = (|acc[127:96]) || too_big;
    if (mul_sat) begin
      mul_val = mul_neg ? SAT_MIN : SAT_MAX;
    end else begin
      mul_val = mul_neg ? (64'd0 - r) : r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantity    <= 2'd0;
      wave_number <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_QUANTITY) begin
        quantity <= cfg_data[1:0];
      end else if (cfg_index == CFG_WAVE_NUMBER) begin
        wave_number <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tail          <= 1'b0;
      step          <= 4'd0;
      mul_cnt       <= 3'd0;
      running_sum   <= 64'd0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            item <= in_data;
            step <= 4'd0;
            tail <= in_data.void_site;
            // A void item that is not last changes nothing.
            if (!(in_data.void_site && !in_data.last)) begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          unique case (uop.op)
            OP_MUL: begin
              mul_a   <= magnitude(opa);
              mul_b   <= magnitude(opb);
              mul_neg <= opa[63] ^ opb[63];
              mul_dst <= uop.dst;
              acc     <= 128'd0;
              mul_cnt <= 3'd0;
              state   <= S_MUL;
            end
            OP_ADD, OP_SUB: begin
              unique case (uop.dst)
                DST_T0:  t0 <= alu_val;
                DST_T1:  t1 <= alu_val;
                DST_T2:  t2 <= alu_val;
                default: running_sum <= alu_val;
              endcase
              overflow_seen <= overflow_seen | alu_sat;
              step          <= step + 4'd1;
            end
            OP_CHK: begin
              step <= 4'd0;
              if (item.last) begin
                tail <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end
            default: begin
              if (out_free) begin
                out_data.cross_section <= t0;
                out_data.saturated     <= overflow_seen;
                running_sum            <= 64'd0;
                overflow_seen          <= 1'b0;
                tail                   <= 1'b0;
                state                  <= S_IDLE;
              end
            end
          endcase
        end
        S_MUL: begin
          if (mul_cnt <= 3'd3) begin
            pp    <= a_half * b_half;
            pp_sh <= (mul_cnt == 3'd0) ? 2'd0 : ((mul_cnt == 3'd3) ? 2'd2 : 2'd1);
          end
          if (mul_cnt >= 3'd1 && mul_cnt <= 3'd4) begin
            acc <= acc + pp_ext;
          end
          if (mul_cnt == 3'd5) begin
            unique case (mul_dst)
              DST_T0:  t0 <= mul_val;
              DST_T1:  t1 <= mul_val;
              DST_T2:  t2 <= mul_val;
              default: running_sum <= mul_val;
            endcase
            overflow_seen <= overflow_seen | mul_sat;
            step          <= step + 4'd1;
            mul_cnt       <= 3'd0;
            state         <= S_RUN;
          end else begin
            mul_cnt <= mul_cnt + 3'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && uop.op == OP_DONE && out_free)
      |=> (running_sum == 64'd0 && !overflow_seen && out_valid))
    else $error("sum or overflow flag not cleared after a result");

  a_tail_only_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && tail) |-> item.last)
    else $error("scaling tail entered for an item that is not last");

  a_body_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.void_site) |=> (state == S_RUN && !tail && step == 4'd0))
    else $error("non-void item did not start its micro-program");

  a_mul_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_MUL) |-> (mul_cnt == 3'd0))
    else $error("multiplier count left running outside a product");

endmodule

// ===== test/cross_section_check_pkg.sv =====
`timescale 1ns / 1ps

package cross_section_check_pkg;

  import dcsa_pkg::*;

  typedef logic signed [63:0] q32_t;

  typedef enum logic [1:0] {
    QTY_EXTINCTION,
    QTY_ABSORPTION,
    QTY_DIFFERENCE,
    QTY_DIFFERENCE_ALIAS
  } quantity_e;

  localparam int unsigned MAX_PRINTED = 200;

  class cross_section_scoreboard;

    logic [1:0]  quantity;
    logic [30:0] wave_number;
    q32_t        running_sum;
    bit          overflow_seen;
    out_item_t   expected_sections[$];
    int unsigned errors;

    function new();
      quantity      = QTY_EXTINCTION;
      wave_number   = 31'd65536;
      running_sum   = '0;
      overflow_seen = 1'b0;
      errors        = 0;
    endfunction

    function int unsigned pending();
      return expected_sections.size();
    endfunction

    function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_QUANTITY) begin
        quantity = data[1:0];
      end else if (idx == CFG_WAVE_NUMBER) begin
        wave_number = data;
      end
    endfunction

    function q32_t widen(input logic signed [31:0] v);
      q32_t w;
      w = {{32{v[31]}}, v};
      return w << WIDEN_SH;
    endfunction

    // Product of two Q32.32 values, magnitude truncated, saturated to 64 bits.
    function q32_t sat_mul(input q32_t a, input q32_t b);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  r;
      logic [63:0]  limit;
      logic [127:0] prod;
      bit           neg;
      ua    = a[63] ? -a : a;
      ub    = b[63] ? -b : b;
      neg   = a[63] ^ b[63];
      prod  = ua * ub;
      r     = prod[95:32];
      limit = neg ? SAT_MIN : SAT_MAX;
      if (prod[127:96] != '0 || r > limit) begin
        overflow_seen = 1'b1;
        return neg ? SAT_MIN : SAT_MAX;
      end
      return neg ? -r : r;
    endfunction

    function q32_t sat_add(input q32_t a, input q32_t b);
      q32_t s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
        overflow_seen = 1'b1;
        return SAT_MAX;
      end
      if (a[63] && b[63] && !s[63]) begin
        overflow_seen = 1'b1;
        return SAT_MIN;
      end
      return s;
    endfunction

    function q32_t sat_sub(input q32_t a, input q32_t b);
      q32_t s;
      s = a - b;
      if (!a[63] && b[63] && s[63]) begin
        overflow_seen = 1'b1;
        return SAT_MAX;
      end
      if (a[63] && !b[63] && !s[63]) begin
        overflow_seen = 1'b1;
        return SAT_MIN;
      end
      return s;
    endfunction

    // Called on every accepted input transfer; a last item queues one cross section.
    function void note_item(input in_item_t it);
      q32_t      pr, pi, er, ei, cr, ci, k;
      q32_t      term, a, b, d, cabs, scaled;
      out_item_t res;
      pr = widen(it.moment_re);
      pi = widen(it.moment_im);
      er = widen(it.field_re);
      ei = widen(it.field_im);
      cr = widen(it.coef_re);
      ci = widen(it.coef_im);
      k  = {33'b0, wave_number} << WIDEN_SH;
      if (!it.void_site) begin
        if (quantity == QTY_EXTINCTION) begin
          a    = sat_add(sat_mul(er, pr), sat_mul(ei, pi));
          b    = sat_sub(sat_mul(ei, pr), sat_mul(er, pi));
          term = sat_sub(sat_mul(ci, a), sat_mul(cr, b));
        end else if (quantity == QTY_ABSORPTION) begin
          d    = sat_mul(sat_mul(sat_mul(k, k), k), TWO_THIRDS_Q32);
          cabs = sat_add(sat_mul(cr, cr), sat_mul(ci, ci));
          a    = sat_add(sat_mul(pr, pr), sat_mul(pi, pi));
          term = sat_mul(a, sat_sub(ci, sat_mul(d, cabs)));
        end else begin
          a    = sat_add(sat_mul(pr, er), sat_mul(pi, ei));
          b    = sat_sub(sat_mul(pi, er), sat_mul(pr, ei));
          term = sat_add(sat_mul(ci, a), sat_mul(cr, b));
        end
        running_sum = sat_add(running_sum, term);
      end
      if (it.last) begin
        scaled = sat_mul(running_sum, sat_mul(FOUR_PI_Q32, k));
        // Both difference codes flip the sign of the scaled sum.
        if (quantity == QTY_DIFFERENCE || quantity == QTY_DIFFERENCE_ALIAS) begin
          scaled = sat_sub('0, scaled);
        end
        res.cross_section = scaled;
        res.saturated     = overflow_seen;
        expected_sections.push_back(res);
        running_sum   = '0;
        overflow_seen = 1'b0;
      end
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTED) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (expected_sections.size() == 0) begin
        report($sformatf("unexpected result cross_section=%h saturated=%b",
                         got.cross_section, got.saturated));
        return;
      end
      want = expected_sections.pop_front();
      if (got.cross_section !== want.cross_section) begin
        report($sformatf("cross_section got %h want %h", got.cross_section,
                         want.cross_section));
      end
      if (got.saturated !== want.saturated) begin
        report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      end
    endtask

  endclass

endpackage

// ===== test/dipole_cross_section_accumulator_tb.sv =====
`timescale 1ns / 1ps

module dipole_cross_section_accumulator_tb;

  import dcsa_pkg::*;
  import cross_section_check_pkg::*;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [30:0] K_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0] K_ONE  = 31'd65536;

  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned HOLD_AT_RESULT  = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  cross_section_scoreboard sb = new();
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  always #6 clk = ~clk;

  dipole_cross_section_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dipole_cross_section_accumulator regression: fail");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [31:0] pr, input logic [31:0] pi,
                                         input logic [31:0] er, input logic [31:0] ei,
                                         input logic [31:0] cr, input logic [31:0] ci,
                                         input logic void_site, input logic last);
    in_item_t it;
    it.moment_re = pr;
    it.moment_im = pi;
    it.field_re  = er;
    it.field_im  = ei;
    it.coef_re   = cr;
    it.coef_im   = ci;
    it.void_site = void_site;
    it.last      = last;
    return it;
  endfunction

  // Mostly moderate magnitudes so sums stay in range, with full-width and edge words mixed in.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    int unsigned bits;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0: w = Q_MAX;
        1: w = Q_MIN;
        2: w = Q_ZERO;
        3: w = 32'hFFFF_FFFF;
        default: w = 32'h0000_0001;
      endcase
    end else if (pick <= 2) begin
      w = $urandom;
    end else begin
      bits = $urandom_range(4, 22);
      w = $urandom & ((32'h1 << bits) - 32'h1);
      if ($urandom_range(0, 1) == 1) begin
        w = -w;
      end
    end
    return w;
  endfunction

  function automatic in_item_t random_item(input logic last);
    return make_item(random_word(), random_word(), random_word(), random_word(),
                     random_word(), random_word(), $urandom_range(0, 7) == 0, last);
  endfunction

  function automatic int unsigned sender_gap();
    if ((items_sent % 128) < 24) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A non-last item may still be in the datapath after the final result transfer.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(make_item(Q_ONE, 32'h0002_0000, 32'h0000_8000, 32'hFFFE_8000,
                        32'h0003_0000, 32'hFFFF_C000, 1'b0, 1'b1));
    send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b1));
    send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b1));
    // A void item that is also last still returns the (empty) sum.
    send_item(make_item(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1, 1'b1));
    send_item(make_item(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1, 1'b0));
    send_item(make_item(Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 32'h0000_0001,
                        1'b0, 1'b1));
    release_input();
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned set_len;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int unsigned j = 0; j < set_len; j++) begin
        send_item(random_item(j == set_len - 1));
        sent++;
      end
    end
    release_input();
  endtask

  // Result side: one long hold-off once, short runs with no stall, random stalls otherwise.
  initial begin
    int unsigned gap;
    int unsigned results_taken;
    results_taken = 0;
    gap = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      out_ready <= (gap == 0);
      if (gap > 0) begin
        gap--;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_taken++;
        if (results_taken == HOLD_AT_RESULT) begin
          gap = HOLD_CYCLES;
        end else if ((results_taken % 16) < 3) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 15);
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] k_value;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values first, then absorption at the reset wave number, then both difference codes with new wave numbers.
    run_directed();
    settle();
    write_register(CFG_QUANTITY, 31'(QTY_ABSORPTION));
    run_directed();
    settle();
    write_register(CFG_QUANTITY, 31'(QTY_DIFFERENCE));
    write_register(CFG_WAVE_NUMBER, K_MAX);
    run_directed();
    settle();
    write_register(CFG_QUANTITY, 31'(QTY_DIFFERENCE_ALIAS));
    write_register(CFG_WAVE_NUMBER, '0);
    run_directed();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 5)
        0: k_value = K_ONE;
        1: k_value = 31'($urandom_range(1, 32'h0004_0000));
        2: k_value = K_MAX;
        3: k_value = '0;
        default: k_value = 31'($urandom);
      endcase
      write_register(CFG_QUANTITY, 31'(p % 4));
      write_register(CFG_WAVE_NUMBER, k_value);
      run_random_phase(ITEMS_PER_PHASE);
    end

    settle();
    if (sb.errors == 0) begin
      $display("dipole_cross_section_accumulator regression: pass");
    end else begin
      $display("dipole_cross_section_accumulator regression: fail");
    end
    $finish;
  end

endmodule
